### rtl/core/pba_pkg.sv
//------------------------------------------------------------------------------
// pba_pkg
// Shared types and constants for the page bitmap allocator.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package pba_pkg;

    localparam int PAGES       = 4096;
    localparam int PAGE_BYTES  = 4096;
    localparam int WORD_BITS   = 64;
    localparam int MAP_WORDS   = PAGES / WORD_BITS;
    localparam int WORD_AW     = $clog2(MAP_WORDS);
    localparam int BIT_AW      = $clog2(WORD_BITS);
    localparam int PAGE_AW     = WORD_AW + BIT_AW;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int CNT_W       = 13;
    localparam int ADDR_W      = 24;
    localparam logic [CNT_W-1:0] EMPTY_TOTAL = CNT_W'(1024);
    localparam logic [CNT_W-1:0] PAGES_CNT   = CNT_W'(PAGES);

    typedef enum logic [1:0] {
        REQ_MARK      = 2'd0,
        REQ_RECOUNT   = 2'd1,
        REQ_ALLOC_ONE = 2'd2,
        REQ_ALLOC_RUN = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_WORD,
        ST_BIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] first_page;
        logic [12:0] page_count;
        logic        mark_used;
    } pba_req_t;

    typedef struct packed {
        logic        ok;
        logic [11:0] page_index;
        logic [23:0] page_address;
        logic [12:0] free_count;
        logic [12:0] total_count;
    } pba_rsp_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] marked_word;
        logic [BIT_AW:0]      free_cnt;
        logic                 has_free;
        logic [BIT_AW-1:0]    top_bit;
        logic                 all_used;
        logic                 all_free;
    } word_info_t;

endpackage

### rtl/core/page_bitmap_allocator_top.sv
//------------------------------------------------------------------------------
// page_bitmap_allocator_top
// Bitmap page frame allocator with one word-wide bitmap RAM.
//------------------------------------------------------------------------------
// After reset the block runs a pass that writes every bitmap word to
// all used; busy stays high meanwhile. One transaction is taken when start is
// high and busy low; its result appears on rsp with done high for exactly one
// cycle, and the receiver must take it then. Each bitmap word passes through a read
// state and a process state on the single RAM port: a range mark or recount
// visits every word, a single-page allocation walks the words and then the bits
// of the word that holds the free page, and a run allocation walks bit by bit
// through partly used words and then rewrites the words the run covers.
`timescale 1ns / 1ps

module page_bitmap_allocator_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pba_pkg::pba_req_t req,
    output logic              done,
    output pba_pkg::pba_rsp_t rsp
);
    import pba_pkg::*;

    state_t               state_reg, state_next;
    req_kind_t            op_reg, op_next;
    logic                 alloc_reg, alloc_next;
    logic                 mark_reg, mark_next;
    logic [11:0]          first_reg, first_next;
    logic [12:0]          cnt_reg, cnt_next;
    logic [WORD_AW-1:0]   w_reg, w_next;
    logic [WORD_AW-1:0]   wend_reg, wend_next;
    logic [BIT_AW-1:0]    b_reg, b_next;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic [CNT_W-1:0]     nfree_reg, nfree_next;
    logic [CNT_W-1:0]     top_reg, top_next;
    logic [CNT_W-1:0]     free_reg, free_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic                 ok_reg, ok_next;
    logic [11:0]          index_reg, index_next;

    logic                 ram_re;
    logic                 ram_we;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    word_info_t           info;

    logic                 cur_bit;
    logic [CNT_W-1:0]     bit_run;
    logic [CNT_W-1:0]     run_start;
    logic [CNT_W-1:0]     nfree_sum;
    logic [CNT_W-1:0]     top_sum;

    pba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(MAP_WORDS)
    ) u_ram (
        .clk  (clk),
        .re   (ram_re),
        .we   (ram_we),
        .addr (w_reg),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    pba_word_ops u_word_ops (
        .word_idx  (w_reg),
        .word      (ram_rdata),
        .first_page(first_reg),
        .page_count(cnt_reg),
        .mark_used (mark_reg),
        .info      (info)
    );

    assign cur_bit   = ram_rdata[b_reg];
    assign bit_run   = cur_bit ? '0 : run_reg + 1'b1;
    assign run_start = CNT_W'({w_reg, b_reg}) + 1'b1 - cnt_reg;
    assign nfree_sum = nfree_reg + CNT_W'(info.free_cnt);
    assign top_sum   = CNT_W'({w_reg, info.top_bit}) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            w_reg     <= '0;
            free_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            w_reg     <= w_next;
            free_reg  <= free_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        alloc_reg <= alloc_next;
        mark_reg  <= mark_next;
        first_reg <= first_next;
        cnt_reg   <= cnt_next;
        wend_reg  <= wend_next;
        b_reg     <= b_next;
        run_reg   <= run_next;
        nfree_reg <= nfree_next;
        top_reg   <= top_next;
        ok_reg    <= ok_next;
        index_reg <= index_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        alloc_next = alloc_reg;
        mark_next  = mark_reg;
        first_next = first_reg;
        cnt_next   = cnt_reg;
        w_next     = w_reg;
        wend_next  = wend_reg;
        b_next     = b_reg;
        run_next   = run_reg;
        nfree_next = nfree_reg;
        top_next   = top_reg;
        free_next  = free_reg;
        total_next = total_reg;
        ok_next    = ok_reg;
        index_next = index_reg;

        case (state_reg)
            ST_INIT:
            begin
                w_next = w_reg + 1'b1;
                if (&w_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = req_kind_t'(req.req_type);
                    alloc_next = 1'b0;
                    mark_next  = req.mark_used;
                    first_next = req.first_page;
                    cnt_next   = (req.req_type == REQ_ALLOC_ONE) ? 13'd1 : req.page_count;
                    w_next     = '0;
                    wend_next  = '1;
                    b_next     = '0;
                    run_next   = '0;
                    nfree_next = '0;
                    top_next   = '0;
                    ok_next    = 1'b0;
                    index_next = '0;
                    if (req.req_type == REQ_ALLOC_RUN &&
                        (req.page_count == '0 || req.page_count > PAGES_CNT))
                        state_next = ST_DONE;
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WORD;
            end
            ST_WORD:
            begin
                case (op_reg)
                    REQ_MARK:
                    begin
                        if (w_reg == wend_reg)
                        begin
                            ok_next    = 1'b1;
                            state_next = ST_DONE;
                            if (alloc_reg)
                            begin
                                index_next = first_reg;
                                free_next  = (free_reg >= cnt_reg) ? free_reg - cnt_reg : '0;
                            end
                        end
                        else
                        begin
                            w_next     = w_reg + 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    REQ_RECOUNT:
                    begin
                        nfree_next = nfree_sum;
                        if (info.has_free)
                            top_next = top_sum;
                        if (&w_reg)
                        begin
                            ok_next    = 1'b1;
                            free_next  = nfree_sum;
                            if (info.has_free)
                                total_next = top_sum;
                            else if (top_reg == '0)
                                total_next = EMPTY_TOTAL;
                            else
                                total_next = top_reg;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            w_next     = w_reg + 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                        if (info.all_used ||
                            (info.all_free && (14'(run_reg) + 14'(WORD_BITS) < 14'(cnt_reg))))
                        begin
                            run_next = info.all_used ? '0 : run_reg + CNT_W'(WORD_BITS);
                            if (&w_reg)
                                state_next = ST_DONE;
                            else
                            begin
                                w_next     = w_reg + 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        else
                        begin
                            b_next     = '0;
                            state_next = ST_BIT;
                        end
                    end
                endcase
            end
            ST_BIT:
            begin
                run_next = bit_run;
                if (bit_run == cnt_reg)
                begin
                    op_next    = REQ_MARK;
                    alloc_next = 1'b1;
                    mark_next  = 1'b1;
                    first_next = run_start[11:0];
                    wend_next  = w_reg;
                    w_next     = run_start[PAGE_AW-1:BIT_AW];
                    state_next = ST_READ;
                end
                else if (&b_reg)
                begin
                    if (&w_reg)
                        state_next = ST_DONE;
                    else
                    begin
                        w_next     = w_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = info.marked_word;
        busy      = 1'b1;
        done      = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = '1;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_WORD:
            begin
                ram_we = (op_reg == REQ_MARK);
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign rsp.ok           = ok_reg;
    assign rsp.page_index   = index_reg;
    assign rsp.page_address = ADDR_W'({index_reg, {PAGE_SHIFT{1'b0}}});
    assign rsp.free_count   = free_reg;
    assign rsp.total_count  = total_reg;

endmodule

### rtl/core/pba_ram.sv
//------------------------------------------------------------------------------
// pba_ram
// Generic single-port synchronous RAM with registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/pba_word_ops.sv
//------------------------------------------------------------------------------
// pba_word_ops
// Per-word bitmap operations: range mask, free-bit count, highest free bit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module pba_word_ops (
    input  logic [pba_pkg::WORD_AW-1:0]   word_idx,
    input  logic [pba_pkg::WORD_BITS-1:0] word,
    input  logic [11:0]                   first_page,
    input  logic [12:0]                   page_count,
    input  logic                          mark_used,
    output pba_pkg::word_info_t           info
);
    import pba_pkg::*;

    logic [13:0]          base;
    logic [13:0]          last_raw;
    logic [13:0]          range_end;
    logic [13:0]          first_ext;
    logic [BIT_AW:0]      lo;
    logic [BIT_AW:0]      hi;
    logic [WORD_BITS-1:0] ones;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_w;
    logic [BIT_AW:0]      cnt;
    logic [BIT_AW-1:0]    top;

    assign ones      = '1;
    assign base      = 14'({word_idx, {BIT_AW{1'b0}}});
    assign first_ext = 14'(first_page);
    assign last_raw  = first_ext + 14'(page_count);
    assign range_end = (last_raw > 14'(PAGES)) ? 14'(PAGES) : last_raw;

    always_comb
    begin
        if (first_ext <= base)
            lo = '0;
        else if (first_ext >= base + 14'(WORD_BITS))
            lo = (BIT_AW+1)'(WORD_BITS);
        else
            lo = (BIT_AW+1)'(first_ext - base);

        if (range_end <= base)
            hi = '0;
        else if (range_end >= base + 14'(WORD_BITS))
            hi = (BIT_AW+1)'(WORD_BITS);
        else
            hi = (BIT_AW+1)'(range_end - base);
    end

    assign mask   = (ones << lo) & ~(ones << hi);
    assign free_w = ~word;

    always_comb
    begin
        cnt = '0;
        top = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            cnt = cnt + (BIT_AW+1)'(free_w[i]);
            if (free_w[i])
                top = BIT_AW'(i);
        end
    end

    assign info.marked_word = mark_used ? (word | mask) : (word & ~mask);
    assign info.free_cnt    = cnt;
    assign info.has_free    = |free_w;
    assign info.top_bit     = top;
    assign info.all_used    = &word;
    assign info.all_free    = ~|word;

endmodule

### tb/page_bitmap_allocator_top_test.sv
//------------------------------------------------------------------------------
// page_bitmap_allocator_top_test
// Self-checking bench for the page bitmap allocator: random and directed
// transactions are predicted by a bitmap model and every response is compared.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_bitmap_allocator_top_test;

    import pba_pkg::*;

    class alloc_scoreboard;
        bit [PAGES-1:0] used_bits;
        bit [12:0]      free_held;
        bit [12:0]      total_held;
        pba_rsp_t       pending[$];
        int             errors;

        function new();
            used_bits  = '1;
            free_held  = '0;
            total_held = '0;
            errors     = 0;
        endfunction

        function void take(int n);
            free_held = (free_held >= n) ? 13'(free_held - n) : '0;
        endfunction

        function void note_request(pba_req_t r);
            pba_rsp_t e;
            int       nfree;
            int       top;
            int       run;
            e = '0;
            e.ok = 1'b1;
            case (req_kind_t'(r.req_type))
                REQ_MARK:
                begin
                    for (int p = 0; p < r.page_count; p++)
                    begin
                        if (r.first_page + p >= PAGES)
                            break;
                        used_bits[r.first_page + p] = r.mark_used;
                    end
                end
                REQ_RECOUNT:
                begin
                    nfree = 0;
                    top   = 0;
                    for (int p = 0; p < PAGES; p++)
                    begin
                        if (!used_bits[p])
                        begin
                            nfree++;
                            top = p + 1;
                        end
                    end
                    if (top == 0)
                        top = 1024;
                    free_held  = (nfree > 8191) ? 13'd8191 : nfree[12:0];
                    total_held = (top > 8191) ? 13'd8191 : top[12:0];
                end
                REQ_ALLOC_ONE:
                begin
                    e.ok = 1'b0;
                    for (int p = 0; p < PAGES; p++)
                    begin
                        if (!used_bits[p])
                        begin
                            used_bits[p] = 1'b1;
                            take(1);
                            e.ok = 1'b1;
                            e.page_index = p[11:0];
                            break;
                        end
                    end
                end
                default:
                begin
                    e.ok = 1'b0;
                    run  = 0;
                    if (r.page_count != 0 && r.page_count <= PAGES)
                    begin
                        for (int p = 0; p < PAGES; p++)
                        begin
                            run = used_bits[p] ? 0 : run + 1;
                            if (run == r.page_count)
                            begin
                                for (int i = p + 1 - run; i <= p; i++)
                                    used_bits[i] = 1'b1;
                                take(run);
                                e.ok = 1'b1;
                                e.page_index = 12'(p + 1 - run);
                                break;
                            end
                        end
                    end
                end
            endcase
            e.page_address = 24'(e.page_index * PAGE_BYTES);
            e.free_count   = free_held;
            e.total_count  = total_held;
            pending.push_back(e);
        endfunction

        function void check_response(pba_rsp_t a);
            pba_rsp_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected response %p", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.ok !== e.ok)
            begin
                $error("ok exp %0d got %0d", e.ok, a.ok);
                errors++;
            end
            if (a.page_index !== e.page_index)
            begin
                $error("page_index exp %0d got %0d", e.page_index, a.page_index);
                errors++;
            end
            if (a.page_address !== e.page_address)
            begin
                $error("page_address exp %0h got %0h", e.page_address, a.page_address);
                errors++;
            end
            if (a.free_count !== e.free_count)
            begin
                $error("free_count exp %0d got %0d", e.free_count, a.free_count);
                errors++;
            end
            if (a.total_count !== e.total_count)
            begin
                $error("total_count exp %0d got %0d", e.total_count, a.total_count);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 50_000_000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    pba_req_t       req;
    logic           done;
    pba_rsp_t       rsp;
    alloc_scoreboard board;
    int             cycles = 0;

    page_bitmap_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_response(rsp);
        if (rst_n && start && !busy)
            board.note_request(req);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(req_kind_t kind, int first, int count, bit used);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(negedge clk);
        req.req_type   = kind;
        req.first_page = first[11:0];
        req.page_count = count[12:0];
        req.mark_used  = used;
        start          = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start = 1'b0;
        req   = pba_req_t'(28'($urandom));
    endtask

    task automatic drain;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_request;
        int pick;
        int count;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            count = $urandom_range(0, 4096);
        else if ($urandom_range(0, 9) == 0)
            count = $urandom_range(4097, 8191);
        else
            count = $urandom_range(0, 80);
        if (pick < 45)
            send_request(REQ_MARK, $urandom_range(0, 4095), count,
                         1'($urandom_range(0, 1)));
        else if (pick < 55)
            send_request(REQ_RECOUNT, $urandom, $urandom, 1'($urandom));
        else if (pick < 78)
            send_request(REQ_ALLOC_ONE, $urandom, $urandom, 1'($urandom));
        else
            send_request(REQ_ALLOC_RUN, $urandom, count, 1'($urandom));
    endtask

    initial
    begin
        board  = new();
        rst_n  = 1'b0;
        start  = 1'b0;
        req    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(REQ_ALLOC_ONE, 0, 0, 0);
        send_request(REQ_RECOUNT, 0, 0, 0);
        send_request(REQ_ALLOC_RUN, 0, 1, 0);
        send_request(REQ_MARK, 0, 4096, 0);
        send_request(REQ_RECOUNT, 4095, 8191, 1);
        send_request(REQ_ALLOC_RUN, 0, 0, 0);
        send_request(REQ_ALLOC_RUN, 0, 4097, 0);
        send_request(REQ_ALLOC_RUN, 0, 8191, 1);
        send_request(REQ_ALLOC_RUN, 0, 4096, 0);
        send_request(REQ_ALLOC_ONE, 0, 0, 0);
        send_request(REQ_MARK, 4095, 8191, 0);
        send_request(REQ_MARK, 4000, 200, 0);
        send_request(REQ_RECOUNT, 0, 0, 0);
        send_request(REQ_ALLOC_ONE, 0, 0, 0);
        send_request(REQ_ALLOC_RUN, 0, 50, 0);
        send_request(REQ_ALLOC_RUN, 0, 100, 0);
        send_request(REQ_MARK, 10, 0, 0);
        send_request(REQ_MARK, 63, 66, 0);
        send_request(REQ_ALLOC_RUN, 0, 66, 0);
        send_request(REQ_MARK, 0, 4096, 0);
        send_request(REQ_RECOUNT, 0, 0, 0);
        send_request(REQ_MARK, 2048, 2048, 1);
        drain();

        for (int n = 0; n < 1800; n++)
        begin
            random_request();
            if (n == 900)
                drain();
        end

        drain();
        repeat (5000) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
